// ----- design/rpn_pkg.sv -----
package rpn_pkg;

    // Data format: signed Q16.16
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = Q_W + FRAC_W;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int ACTION_W  = 3;

    // Serial unit step counts
    localparam int ADD_STEPS = Q_W;
    localparam int MUL_STEPS = Q_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int DEFAULT_STACK_DEPTH = 128;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_SUB    = 3'd2,
        ACT_MUL    = 3'd3,
        ACT_DIV    = 3'd4,
        ACT_FINISH = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_SAT     = 3'd4
    } status_t;

endpackage

// ----- design/rpn_stack_calculator_unit.sv -----
// Push, stack errors and undefined actions pass from decode to emit; finish may read the new
// top from memory first; arithmetic reads, runs its serial loop (not on a zero divisor), then a fix step.
// One request in flight at a time; the bit-serial add, shift-add multiply and
// restoring divide loops (one bit per cycle) set the rate.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n, async) empties the stack; operand memory contents are not cleared.
module rpn_stack_calculator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [Q_W-1:0]      operand_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [Q_W-1:0]      top_value,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_ADD    = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_FIX    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         depth_reg, depth_next;
    logic [Q_W-1:0]        top_reg, top_next;
    action_t               act_reg, act_next;
    logic [Q_W-1:0]        opnd_reg, opnd_next;

    // Serial datapath shift registers
    logic [Q_W-1:0]        sh_a_reg, sh_a_next;
    logic [DIV_W-1:0]      sh_b_reg, sh_b_next;
    logic [Q_W:0]          acc_reg, acc_next;
    logic                  carry_reg, carry_next;
    logic                  ovf_reg, ovf_next;
    logic                  neg_reg, neg_next;
    logic                  dz_reg, dz_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    status_t               emit_status_reg, emit_status_next;
    logic [Q_W-1:0]        emit_top_reg, emit_top_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               status_out_reg, status_out_next;
    logic [Q_W-1:0]        top_out_reg, top_out_next;
    logic [COUNT_W-1:0]    count_out_reg, count_out_next;

    // Operand memory
    logic [Q_W-1:0]        mem [STACK_DEPTH];
    logic [Q_W-1:0]        rd_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [Q_W-1:0]        mem_wdata;

    logic [CW-1:0]         depth_m1;
    logic [CW-1:0]         depth_m2;
    logic [CW+COUNT_W-1:0] depth_wide;
    logic                  full;
    logic                  under2;
    logic [Q_W-1:0]        top_or_zero;
    logic [Q_W-1:0]        rd_mag;
    logic [Q_W-1:0]        top_mag;

    // Add/subtract bit slice
    logic                  sub_mode;
    logic                  add_b;
    logic                  add_s;
    logic                  add_c;

    // Multiply step
    logic                  mul_last;
    logic [Q_W:0]          mul_addend;
    logic [Q_W:0]          mul_sum;

    // Divide step
    logic [Q_W:0]          div_sh;
    logic                  div_ge;
    logic [Q_W:0]          div_diff;

    // Final result
    logic [2*Q_W-1:0]      prod;
    logic                  mul_fits;
    logic                  q_pos_fit;
    logic                  q_neg_fit;
    logic [Q_W-1:0]        q_low;
    logic [Q_W-1:0]        fix_val;
    status_t               fix_status;

    assign depth_m1    = depth_reg - CW'(1);
    assign depth_m2    = depth_reg - CW'(2);
    assign depth_wide  = {{COUNT_W{1'b0}}, depth_reg};
    assign full        = (depth_reg == CW'(STACK_DEPTH));
    assign under2      = (depth_reg < CW'(2));
    assign top_or_zero = (depth_reg != '0) ? top_reg : '0;
    assign rd_mag      = rd_reg[Q_W-1] ? (~rd_reg + Q_W'(1)) : rd_reg;
    assign top_mag     = top_reg[Q_W-1] ? (~top_reg + Q_W'(1)) : top_reg;

    // Full adder over one bit per cycle, LSB first
    assign sub_mode = (act_reg == ACT_SUB);
    assign add_b    = sh_b_reg[0] ^ sub_mode;
    assign add_s    = sh_a_reg[0] ^ add_b ^ carry_reg;
    assign add_c    = (sh_a_reg[0] & add_b) | (sh_a_reg[0] & carry_reg) | (add_b & carry_reg);

    // Signed shift-add multiply; MSB of the multiplier carries negative weight
    assign mul_last   = (cnt_reg == CNT_W'(MUL_STEPS - 1));
    assign mul_addend = sh_b_reg[0] ? {sh_a_reg[Q_W-1], sh_a_reg} : '0;
    assign mul_sum    = mul_last ? (acc_reg - mul_addend) : (acc_reg + mul_addend);

    // Restoring divide on magnitudes
    assign div_sh   = {acc_reg[Q_W-1:0], sh_b_reg[DIV_W-1]};
    assign div_ge   = (div_sh >= {1'b0, sh_a_reg});
    assign div_diff = div_sh - {1'b0, sh_a_reg};

    // Saturation and result select
    assign prod      = {acc_reg[Q_W-1:0], sh_b_reg[Q_W-1:0]};
    assign mul_fits  = (&prod[2*Q_W-1:Q_W+FRAC_W-1]) | ~(|prod[2*Q_W-1:Q_W+FRAC_W-1]);
    assign q_pos_fit = ~(|sh_b_reg[DIV_W-1:Q_W-1]);
    assign q_neg_fit = ~(|sh_b_reg[DIV_W-1:Q_W])
                       & (~sh_b_reg[Q_W-1] | ~(|sh_b_reg[Q_W-2:0]));
    assign q_low     = sh_b_reg[Q_W-1:0];

    always_comb
    begin
        fix_val    = acc_reg[Q_W-1:0];
        fix_status = ST_OK;
        case (act_reg)
            ACT_ADD, ACT_SUB:
            begin
                if (ovf_reg)
                begin
                    fix_val    = neg_reg ? Q_MIN : Q_MAX;
                    fix_status = ST_SAT;
                end
            end
            ACT_MUL:
            begin
                if (mul_fits)
                begin
                    fix_val = prod[Q_W+FRAC_W-1:FRAC_W];
                end
                else
                begin
                    fix_val    = prod[2*Q_W-1] ? Q_MIN : Q_MAX;
                    fix_status = ST_SAT;
                end
            end
            ACT_DIV:
            begin
                if (dz_reg)
                begin
                    fix_val    = neg_reg ? Q_MIN : Q_MAX;
                    fix_status = ST_DIVZERO;
                end
                else if (neg_reg)
                begin
                    fix_val = q_neg_fit ? (~q_low + Q_W'(1)) : Q_MIN;
                    if (!q_neg_fit)
                    begin
                        fix_status = ST_SAT;
                    end
                end
                else
                begin
                    fix_val = q_pos_fit ? q_low : Q_MAX;
                    if (!q_pos_fit)
                    begin
                        fix_status = ST_SAT;
                    end
                end
            end
            default:
            begin
                fix_val    = acc_reg[Q_W-1:0];
                fix_status = ST_OK;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        depth_next       = depth_reg;
        top_next         = top_reg;
        act_next         = act_reg;
        opnd_next        = opnd_reg;
        sh_a_next        = sh_a_reg;
        sh_b_next        = sh_b_reg;
        acc_next         = acc_reg;
        carry_next       = carry_reg;
        ovf_next         = ovf_reg;
        neg_next         = neg_reg;
        dz_next          = dz_reg;
        cnt_next         = cnt_reg;
        emit_status_next = emit_status_reg;
        emit_top_next    = emit_top_reg;
        out_valid_next   = out_valid_reg;
        status_out_next  = status_out_reg;
        top_out_next     = top_out_reg;
        count_out_next   = count_out_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = '0;
        mem_raddr        = '0;
        mem_wdata        = '0;

        // Result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action_t'(action);
                    opnd_next  = operand_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                emit_status_next = ST_OK;
                emit_top_next    = top_or_zero;
                state_next       = S_EMIT;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (full)
                        begin
                            emit_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = depth_reg[AW-1:0];
                            mem_wdata     = opnd_reg;
                            top_next      = opnd_reg;
                            depth_next    = depth_reg + CW'(1);
                            emit_top_next = opnd_reg;
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                    begin
                        if (under2)
                        begin
                            emit_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = depth_m2[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                    ACT_FINISH:
                    begin
                        if (depth_reg == '0)
                        begin
                            emit_status_next = ST_EMPTY;
                            emit_top_next    = '0;
                        end
                        else
                        begin
                            emit_top_next = top_reg;
                            depth_next    = depth_m1;
                            // New top lives in memory
                            if (!under2)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = depth_m2[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        emit_status_next = ST_OK;
                    end
                endcase
            end

            S_READ:
            begin
                acc_next = '0;
                cnt_next = '0;
                dz_next  = 1'b0;
                case (act_reg)
                    ACT_FINISH:
                    begin
                        top_next   = rd_reg;
                        state_next = S_EMIT;
                    end
                    ACT_ADD, ACT_SUB:
                    begin
                        sh_a_next  = rd_reg;
                        sh_b_next  = {{FRAC_W{1'b0}}, top_reg};
                        carry_next = sub_mode;
                        state_next = S_ADD;
                    end
                    ACT_MUL:
                    begin
                        sh_a_next  = rd_reg;
                        sh_b_next  = {{FRAC_W{1'b0}}, top_reg};
                        state_next = S_MUL;
                    end
                    ACT_DIV:
                    begin
                        if (top_reg == '0)
                        begin
                            dz_next    = 1'b1;
                            neg_next   = rd_reg[Q_W-1];
                            state_next = S_FIX;
                        end
                        else
                        begin
                            sh_a_next  = top_mag;
                            sh_b_next  = {rd_mag, {FRAC_W{1'b0}}};
                            neg_next   = rd_reg[Q_W-1] ^ top_reg[Q_W-1];
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_ADD:
            begin
                sh_a_next           = {1'b0, sh_a_reg[Q_W-1:1]};
                sh_b_next           = {1'b0, sh_b_reg[DIV_W-1:1]};
                acc_next[Q_W-1:0]   = {add_s, acc_reg[Q_W-1:1]};
                carry_next          = add_c;
                cnt_next            = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ADD_STEPS - 1))
                begin
                    // Sign bit: overflow when carry in and out differ
                    ovf_next   = carry_reg ^ add_c;
                    neg_next   = sh_a_reg[0];
                    state_next = S_FIX;
                end
            end

            S_MUL:
            begin
                acc_next            = {mul_sum[Q_W], mul_sum[Q_W:1]};
                sh_b_next[Q_W-1:0]  = {mul_sum[0], sh_b_reg[Q_W-1:1]};
                cnt_next            = cnt_reg + CNT_W'(1);
                if (mul_last)
                begin
                    state_next = S_FIX;
                end
            end

            S_DIV:
            begin
                acc_next  = div_ge ? div_diff : div_sh;
                sh_b_next = {sh_b_reg[DIV_W-2:0], div_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                // Result replaces the two operands
                mem_we           = 1'b1;
                mem_waddr        = depth_m2[AW-1:0];
                mem_wdata        = fix_val;
                depth_next       = depth_m1;
                top_next         = fix_val;
                emit_status_next = fix_status;
                emit_top_next    = fix_val;
                state_next       = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = emit_status_reg;
                    top_out_next    = emit_top_reg;
                    count_out_next  = depth_wide[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg         <= top_next;
        act_reg         <= act_next;
        opnd_reg        <= opnd_next;
        sh_a_reg        <= sh_a_next;
        sh_b_reg        <= sh_b_next;
        acc_reg         <= acc_next;
        carry_reg       <= carry_next;
        ovf_reg         <= ovf_next;
        neg_reg         <= neg_next;
        dz_reg          <= dz_next;
        cnt_reg         <= cnt_next;
        emit_status_reg <= emit_status_next;
        emit_top_reg    <= emit_top_next;
        status_out_reg  <= status_out_next;
        top_out_reg     <= top_out_next;
        count_out_reg   <= count_out_next;
    end

    // Operand memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_out_reg;
    assign top_value   = top_out_reg;
    assign entry_count = count_out_reg;

endmodule

// ----- tb/rpn_result_checker.sv -----
// Watches both channels of the RPN calculator, predicts one result per
// accepted request from its own copy of the operand stack, and compares.
module rpn_result_checker
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [ACTION_W-1:0]    action,
    input  logic signed [Q_W-1:0]  operand_value,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [STATUS_W-1:0]    status,
    input  logic signed [Q_W-1:0]  top_value,
    input  logic [COUNT_W-1:0]     entry_count,
    output int                     mismatches,
    output int                     awaiting,
    output int                     results_checked,
    output int                     flagged_results
);

    localparam int     STACK_LIMIT = DEFAULT_STACK_DEPTH;
    localparam int     MAX_PRINTED = 30;
    localparam longint WIDE_MAX    = longint'(2147483647);
    localparam longint WIDE_MIN    = -WIDE_MAX - 1;

    typedef struct packed {
        logic [STATUS_W-1:0]   st;
        logic signed [Q_W-1:0] value;
        logic [COUNT_W-1:0]    count;
    } token_result_t;

    // Shadow copy of the operand stack
    logic signed [Q_W-1:0] operand_stack [STACK_LIMIT];
    int                    stack_count;
    token_result_t         expected_results [$];

    initial begin
        mismatches      = 0;
        results_checked = 0;
        flagged_results = 0;
        awaiting        = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one request to the shadow stack and return the result it produces
    function automatic token_result_t evaluate_token(input logic [ACTION_W-1:0] act,
                                                     input logic signed [Q_W-1:0] val);
        token_result_t         r;
        longint                earlier;
        longint                later;
        longint                wide;
        logic signed [Q_W-1:0] combined;
        logic                  shown_set;
        r.st      = ST_OK;
        r.value   = '0;
        shown_set = 1'b0;
        case (act)
            ACT_PUSH:
            begin
                if (stack_count >= STACK_LIMIT)
                    r.st = ST_FULL;
                else
                begin
                    operand_stack[stack_count] = val;
                    stack_count++;
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
            begin
                if (stack_count < 2)
                    r.st = ST_EMPTY;
                else
                begin
                    later   = operand_stack[stack_count-1];
                    earlier = operand_stack[stack_count-2];
                    if (act == ACT_DIV && later == 0)
                    begin
                        // largest magnitude carrying the dividend's sign
                        combined = (earlier < 0) ? Q_MIN : Q_MAX;
                        r.st     = ST_DIVZERO;
                    end
                    else
                    begin
                        case (act)
                            ACT_ADD: wide = earlier + later;
                            ACT_SUB: wide = earlier - later;
                            ACT_MUL: wide = (earlier * later) >>> FRAC_W;  // floor
                            default: wide = (earlier <<< FRAC_W) / later;  // toward zero
                        endcase
                        if (wide > WIDE_MAX)
                        begin
                            combined = Q_MAX;
                            r.st     = ST_SAT;
                        end
                        else if (wide < WIDE_MIN)
                        begin
                            combined = Q_MIN;
                            r.st     = ST_SAT;
                        end
                        else
                            combined = wide[Q_W-1:0];
                    end
                    stack_count--;
                    operand_stack[stack_count-1] = combined;
                end
            end
            ACT_FINISH:
            begin
                shown_set = 1'b1;
                if (stack_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    stack_count--;
                    r.value = operand_stack[stack_count];
                end
            end
            default: ;  // undefined action: nothing changes
        endcase
        if (!shown_set)
            r.value = (stack_count > 0) ? operand_stack[stack_count-1] : '0;
        r.count = COUNT_W'(stack_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_result_t want;
        if (!rst_n)
        begin
            stack_count = 0;
            expected_results.delete();
            awaiting <= 0;
        end
        else
        begin
            // results first: a request taken at this edge cannot answer now
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: st=%0d top=%h n=%0d",
                                              status, top_value, entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_checked, status, want.st));
                    if (top_value !== want.value)
                        report_mismatch($sformatf("result %0d top_value %h, want %h",
                                                  results_checked, top_value, want.value));
                    if (entry_count !== want.count)
                        report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                                  results_checked, entry_count, want.count));
                end
                results_checked++;
                if (status != ST_OK)
                    flagged_results++;
            end
            if (in_valid && in_ready)
                expected_results.push_back(evaluate_token(action, operand_value));
            awaiting <= expected_results.size();
        end
    end

endmodule

// ----- tb/rpn_stack_calculator_unit_test.sv -----
module rpn_stack_calculator_unit_test;
    import rpn_pkg::*;

    localparam int                  STACK_LIMIT  = DEFAULT_STACK_DEPTH;
    localparam int                  ITEM_TARGET  = 900;
    localparam int                  FILL_AT      = 350;
    localparam int                  DRAIN_CYCLES = 64;
    localparam int                  IDLE_PCT     = 33;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
    localparam logic [Q_W-1:0]      Q_ONE        = 32'h0001_0000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic [ACTION_W-1:0]    action        = ACT_PUSH;
    logic signed [Q_W-1:0]  operand_value = '0;
    logic                   out_ready     = 1'b0;
    logic                   steady        = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [STATUS_W-1:0]    status;
    logic signed [Q_W-1:0]  top_value;
    logic [COUNT_W-1:0]     entry_count;

    int mismatches;
    int awaiting;
    int results_checked;
    int flagged_results;
    int requests_sent = 0;
    int plan_depth    = 0;
    int full_runs     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rpn_stack_calculator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .top_value     (top_value),
        .entry_count   (entry_count)
    );

    rpn_result_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .operand_value   (operand_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .top_value       (top_value),
        .entry_count     (entry_count),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .flagged_results (flagged_results)
    );

    // Result side back-pressure
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Operand mix: corner values, small numbers that rarely saturate, raw bits
    function automatic logic signed [Q_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            case ($urandom_range(0, 6))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return '0;
                3: return 32'sd1;
                4: return -32'sd1;
                5: return Q_ONE;
                default: return -$signed(Q_ONE);
            endcase
        end
        else if (sel < 60)
            return $signed(Q_W'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
        else
            return $urandom;
    endfunction

    // Hand one request to the block; valid stays up across back-to-back requests
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic signed [Q_W-1:0] val);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid      <= 1'b1;
        action        <= act;
        operand_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        case (act)
            ACT_PUSH:                          if (plan_depth < STACK_LIMIT) plan_depth++;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: if (plan_depth >= 2) plan_depth--;
            ACT_FINISH:                        if (plan_depth > 0) plan_depth--;
            default: ;
        endcase
    endtask

    function automatic logic [ACTION_W-1:0] pick_operator();
        return ACTION_W'($urandom_range(ACT_ADD, ACT_DIV));
    endfunction

    initial
    begin
        int  terms;
        int  pick;
        int  directed;
        bit  filled;
        filled = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stack, positive saturation, rounding, divide by zero
        send_request(ACT_FINISH, '0);
        send_request(ACT_ADD, '0);
        send_request(ACT_PUSH, Q_MAX);
        send_request(ACT_MUL, '0);
        send_request(ACT_PUSH, Q_MAX);
        send_request(ACT_ADD, '0);
        send_request(ACT_PUSH, Q_MIN);
        send_request(ACT_SUB, '0);
        send_request(ACT_PUSH, -32'sd1);
        send_request(ACT_MUL, '0);
        send_request(ACT_PUSH, '0);
        send_request(ACT_DIV, '0);
        send_request(ACT_PUSH, '0);
        send_request(ACT_DIV, Q_MAX);
        send_request(ACT_FINISH, '0);
        send_request(ACT_PUSH, '0);
        send_request(ACT_PUSH, '0);
        send_request(ACT_DIV, '0);
        send_request(ACT_PUSH, Q_MIN);
        send_request(ACT_PUSH, -$signed(Q_ONE));
        send_request(ACT_DIV, '0);
        send_request(ACT_UNDEF_LO, Q_MIN);
        send_request(ACT_UNDEF_HI, Q_MAX);
        send_request(ACT_FINISH, '0);
        send_request(ACT_FINISH, '0);
        send_request(ACT_FINISH, '0);
        directed = requests_sent;

        while (requests_sent < ITEM_TARGET)
        begin
            if (!filled && requests_sent >= FILL_AT)
            begin
                // Fill to capacity with no idling, overflow it, then unwind
                filled = 1'b1;
                steady <= 1'b1;
                while (plan_depth < STACK_LIMIT)
                    send_request(ACT_PUSH, pick_operand());
                full_runs++;
                send_request(ACT_PUSH, pick_operand());
                send_request(ACT_PUSH, pick_operand());
                steady <= 1'b0;
                repeat (60)
                    send_request(pick_operator(), pick_operand());
                while (plan_depth > 0)
                    send_request(ACT_FINISH, pick_operand());
                send_request(ACT_FINISH, pick_operand());
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // Well-formed expression with random operands and operators
                terms = $urandom_range(2, 6);
                while (plan_depth + terms > STACK_LIMIT)
                    send_request(ACT_FINISH, pick_operand());
                repeat (terms)
                    send_request(ACT_PUSH, pick_operand());
                repeat (terms - 1)
                    send_request(pick_operator(), pick_operand());
                if ($urandom_range(0, 9) < 6)
                    send_request(ACT_FINISH, pick_operand());
            end
            else if (pick < 90)
            begin
                // Noise: any action code, any value
                repeat ($urandom_range(1, 4))
                    send_request(ACTION_W'($urandom_range(0, 7)), $urandom);
            end
            else
            begin
                // Broken sequence: operator short of operands, pops past empty
                while (plan_depth > 1)
                    send_request(ACT_FINISH, pick_operand());
                send_request(pick_operator(), pick_operand());
                send_request(ACT_FINISH, pick_operand());
                send_request(ACT_FINISH, pick_operand());
            end
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d requests (%0d directed), %0d results checked, %0d mismatches",
                 requests_sent, directed, results_checked, mismatches);
        $display("Run: %0d results with error or saturation status, %0d full-stack fills",
                 flagged_results, full_runs);
        if (mismatches == 0 && awaiting == 0)
            $display("rpn_stack_calculator_unit test passed");
        else
            $display("rpn_stack_calculator_unit test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Watchdog expired with %0d results outstanding", awaiting);
        $display("rpn_stack_calculator_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/rpn_pkg.sv
design/rpn_stack_calculator_unit.sv
tb/rpn_result_checker.sv
tb/rpn_stack_calculator_unit_test.sv
